>>> hw/rtl/max_pool_with_argmax_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max pooling core
// Shared property forms; the enclosing scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_WITH_ARGMAX_CORE_ASSERT_SVH
`define MAX_POOL_WITH_ARGMAX_CORE_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define MPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked starting at the edge after the antecedent.
`define MPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared widths, register map, sequencer states and the pooling reciprocal
// table of the max pooling core.
// ----------------------------------------------------------------------------
`default_nettype none

package mpa_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int DIM_W          = 7;
  localparam int POOL_W         = 4;
  localparam int POS_W          = 6;
  localparam int REM_W          = 3;
  localparam int RECIP_W        = 11;
  localparam int RECIP_SHIFT    = 10;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_PLANES_DEF = 64;

  localparam logic [POOL_W-1:0] POOL_MAX = 4'd8;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PLANE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_POOL_SIZE    = 2'd2;

  localparam logic [DIM_W-1:0]  RST_PLANE_WIDTH  = 7'd32;
  localparam logic [DIM_W-1:0]  RST_PLANE_HEIGHT = 7'd32;
  localparam logic [POOL_W-1:0] RST_POOL_SIZE    = 4'd2;

  // Run, or one of the two steps that rebuild the window position.
  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_QUOT = 3'b010,
    ST_REM  = 3'b100
  } seq_state_t;

  // ceil(1024 / ps); exact quotient for dividends below 128.
  function automatic logic [RECIP_W-1:0] pool_recip(input logic [POOL_W-1:0] ps);
    logic [RECIP_W-1:0] r;
    case (ps)
      4'd1:    r = 11'd1024;
      4'd2:    r = 11'd512;
      4'd3:    r = 11'd342;
      4'd4:    r = 11'd256;
      4'd5:    r = 11'd205;
      4'd6:    r = 11'd171;
      4'd7:    r = 11'd147;
      4'd8:    r = 11'd128;
      default: r = 11'd1024;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mpa_ram.sv
// ----------------------------------------------------------------------------
// mpa_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/max_pool_with_argmax_core.sv
// ----------------------------------------------------------------------------
// max_pool_with_argmax_core
// Streaming 2-D max pooling over raster-ordered planes, reporting the value
// and the plane position of each window maximum.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                               | Direction
//   ---------+---------------------------------------+----------
//   input    | in_valid/in_ready, in_sample_value    | in
//   result   | out_valid/out_ready, out_* fields     | out
//   config   | psel/penable/pwrite/paddr/pwdata/...  | in/out
//
// One sample is accepted every cycle while in_ready is high; the
// running-maximum RAM is read when the sample is accepted and written back
// from the update stage, where a window's last sample loads the result.
// After reset and after every register write the window position is rebuilt
// in the quotient and remainder steps, during which in_ready is low.
// A result waiting in the output register stalls the input only when the
// sample behind it also closes a window.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_with_argmax_core #(
  parameter int MAX_WIDTH  = mpa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PLANES = mpa_pkg::MAX_PLANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [mpa_pkg::SAMPLE_W-1:0] in_sample_value,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mpa_pkg::SAMPLE_W-1:0]      out_pooled_value,
  output logic        [mpa_pkg::POS_W-1:0]         out_max_row,
  output logic        [mpa_pkg::POS_W-1:0]         out_max_col,
  output logic        [mpa_pkg::POS_W-1:0]         out_out_row,
  output logic        [mpa_pkg::POS_W-1:0]         out_out_col,
  output logic        [mpa_pkg::POS_W-1:0]         out_plane_index,
  output logic                                     out_plane_done,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic   [mpa_pkg::PADDR_W-1:0]       paddr,
  input  wire logic   [mpa_pkg::PDATA_W-1:0]       pwdata,
  output logic        [mpa_pkg::PDATA_W-1:0]       prdata,
  output logic                                     pready
);

  // Position counters hold values below MAX_WIDTH; compares against the
  // 7-bit registers run one bit wider than either.
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMPW  = ((CW > mpa_pkg::DIM_W) ? CW : mpa_pkg::DIM_W) + 1;
  localparam int PW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PRODW = CMPW + mpa_pkg::RECIP_W;
  localparam int ENTW  = mpa_pkg::SAMPLE_W + 2 * CW;
  localparam int SW    = mpa_pkg::SAMPLE_W;
  localparam int RW    = mpa_pkg::REM_W;
  localparam int QW    = mpa_pkg::POOL_W;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the core is idle; the block itself does not enforce this.
  // --------------------------------------------------------------------------
  logic [mpa_pkg::DIM_W-1:0] cfg_width_r;
  logic [mpa_pkg::DIM_W-1:0] cfg_height_r;
  logic [QW-1:0]             cfg_pool_r;
  logic                      cfg_we;
  logic [1:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= mpa_pkg::RST_PLANE_WIDTH;
      cfg_height_r <= mpa_pkg::RST_PLANE_HEIGHT;
      cfg_pool_r   <= mpa_pkg::RST_POOL_SIZE;
    end else if (cfg_we) begin
      case (cfg_idx)
        mpa_pkg::REG_PLANE_WIDTH:  cfg_width_r  <= pwdata[mpa_pkg::DIM_W-1:0];
        mpa_pkg::REG_PLANE_HEIGHT: cfg_height_r <= pwdata[mpa_pkg::DIM_W-1:0];
        mpa_pkg::REG_POOL_SIZE:    cfg_pool_r   <= pwdata[QW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mpa_pkg::REG_PLANE_WIDTH:  prdata = mpa_pkg::PDATA_W'(cfg_width_r);
      mpa_pkg::REG_PLANE_HEIGHT: prdata = mpa_pkg::PDATA_W'(cfg_height_r);
      mpa_pkg::REG_POOL_SIZE:    prdata = mpa_pkg::PDATA_W'(cfg_pool_r);
      default:                   prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, oversize values saturate.
  logic [CMPW-1:0] w_eff;
  logic [CMPW-1:0] h_eff;
  logic [QW-1:0]   ps_eff;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(cfg_width_r) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = CMPW'(1);
    end else if (CMPW'(cfg_height_r) > CMPW'(MAX_WIDTH)) begin
      h_eff = CMPW'(MAX_WIDTH);
    end else begin
      h_eff = CMPW'(cfg_height_r);
    end
    if (cfg_pool_r == '0) begin
      ps_eff = QW'(1);
    end else if (cfg_pool_r > mpa_pkg::POOL_MAX) begin
      ps_eff = mpa_pkg::POOL_MAX;
    end else begin
      ps_eff = cfg_pool_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. The raster position is kept both as plain counters and as
  // quotient/remainder by the pool size, which the datapath needs every
  // cycle. After reset or a register write the quotients are rebuilt with a
  // reciprocal multiply, and then the remainders are rebuilt from them.
  // --------------------------------------------------------------------------
  mpa_pkg::seq_state_t state_r, state_nxt;

  always_comb begin
    case (state_r)
      mpa_pkg::ST_RUN:  state_nxt = cfg_we ? mpa_pkg::ST_QUOT : mpa_pkg::ST_RUN;
      mpa_pkg::ST_QUOT: state_nxt = cfg_we ? mpa_pkg::ST_QUOT : mpa_pkg::ST_REM;
      mpa_pkg::ST_REM:  state_nxt = cfg_we ? mpa_pkg::ST_QUOT : mpa_pkg::ST_RUN;
      default:          state_nxt = mpa_pkg::ST_QUOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpa_pkg::ST_QUOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Raster position of the next sample.
  logic [CW-1:0]   col_r, col_nxt;
  logic [CW-1:0]   row_r, row_nxt;
  logic [PW-1:0]   plane_r, plane_nxt;
  logic [CW-1:0]   colq_r, colq_nxt;
  logic [CW-1:0]   rowq_r, rowq_nxt;
  logic [RW-1:0]   colrem_r, colrem_nxt;
  logic [RW-1:0]   rowrem_r, rowrem_nxt;
  logic [CMPW-1:0] wout_r;
  logic [CMPW-1:0] hout_r;

  logic [mpa_pkg::RECIP_W-1:0] recip;
  logic [PRODW-1:0] prod_col, prod_row, prod_w, prod_h;
  logic [CMPW-1:0]  colq_ps, rowq_ps;
  logic             in_fire;

  assign recip    = mpa_pkg::pool_recip(ps_eff);
  assign prod_col = PRODW'(col_r) * PRODW'(recip);
  assign prod_row = PRODW'(row_r) * PRODW'(recip);
  assign prod_w   = PRODW'(w_eff) * PRODW'(recip);
  assign prod_h   = PRODW'(h_eff) * PRODW'(recip);
  assign colq_ps  = CMPW'(colq_r) * CMPW'(ps_eff);
  assign rowq_ps  = CMPW'(rowq_r) * CMPW'(ps_eff);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    plane_nxt  = plane_r;
    colq_nxt   = colq_r;
    rowq_nxt   = rowq_r;
    colrem_nxt = colrem_r;
    rowrem_nxt = rowrem_r;
    if (state_r == mpa_pkg::ST_QUOT) begin
      colq_nxt = CW'(prod_col >> mpa_pkg::RECIP_SHIFT);
      rowq_nxt = CW'(prod_row >> mpa_pkg::RECIP_SHIFT);
    end else if (state_r == mpa_pkg::ST_REM) begin
      colrem_nxt = RW'(CMPW'(col_r) - colq_ps);
      rowrem_nxt = RW'(CMPW'(row_r) - rowq_ps);
    end else if (in_fire) begin
      if (CMPW'(col_r) + CMPW'(1) >= w_eff) begin
        col_nxt    = '0;
        colq_nxt   = '0;
        colrem_nxt = '0;
        if (CMPW'(row_r) + CMPW'(1) >= h_eff) begin
          row_nxt    = '0;
          rowq_nxt   = '0;
          rowrem_nxt = '0;
          if ((PW + 1)'(plane_r) + (PW + 1)'(1) >= (PW + 1)'(MAX_PLANES)) begin
            plane_nxt = '0;
          end else begin
            plane_nxt = plane_r + PW'(1);
          end
        end else begin
          row_nxt = row_r + CW'(1);
          if (QW'(rowrem_r) + QW'(1) == ps_eff) begin
            rowq_nxt   = rowq_r + CW'(1);
            rowrem_nxt = '0;
          end else begin
            rowrem_nxt = rowrem_r + RW'(1);
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (QW'(colrem_r) + QW'(1) == ps_eff) begin
          colq_nxt   = colq_r + CW'(1);
          colrem_nxt = '0;
        end else begin
          colrem_nxt = colrem_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

  // Rebuilt by the sequencer before the first sample is taken.
  always_ff @(posedge clk) begin
    colq_r   <= colq_nxt;
    rowq_r   <= rowq_nxt;
    colrem_r <= colrem_nxt;
    rowrem_r <= rowrem_nxt;
    if (state_r == mpa_pkg::ST_QUOT) begin
      wout_r <= CMPW'(prod_w >> mpa_pkg::RECIP_SHIFT);
      hout_r <= CMPW'(prod_h >> mpa_pkg::RECIP_SHIFT);
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: classify the sample and read the running maximum of its
  // window column.
  // --------------------------------------------------------------------------
  logic s0_inside, s0_first, s0_last, s0_pdone;

  assign s0_inside = (CMPW'(colq_r) < wout_r) && (CMPW'(rowq_r) < hout_r);
  assign s0_first  = (colrem_r == '0) && (rowrem_r == '0);
  assign s0_last   = (QW'(colrem_r) == ps_eff - QW'(1)) &&
                     (QW'(rowrem_r) == ps_eff - QW'(1));
  assign s0_pdone  = (CMPW'(rowq_r) == hout_r - CMPW'(1)) &&
                     (CMPW'(colq_r) == wout_r - CMPW'(1));

  // Update stage registers.
  logic                 s1_valid_r;
  logic                 s1_inside_r, s1_first_r, s1_last_r, s1_pdone_r;
  logic signed [SW-1:0] s1_sample_r;
  logic [CW-1:0]        s1_row_r, s1_col_r, s1_orow_r, s1_j_r;
  logic [PW-1:0]        s1_plane_r;
  logic                 s1_adv, s1_we, out_load;

  // The update stage only holds when it closes a window and the output
  // register is still occupied.
  assign s1_adv   = !s1_valid_r || !(s1_inside_r && s1_last_r) || !out_valid || out_ready;
  assign in_ready = (state_r == mpa_pkg::ST_RUN) && s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign s1_we    = s1_valid_r && s1_inside_r && s1_adv;
  assign out_load = s1_we && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_inside_r <= s0_inside;
      s1_first_r  <= s0_first;
      s1_last_r   <= s0_last;
      s1_pdone_r  <= s0_pdone;
      s1_sample_r <= in_sample_value;
      s1_row_r    <= row_r;
      s1_col_r    <= col_r;
      s1_orow_r   <= rowq_r;
      s1_j_r      <= colq_r;
      s1_plane_r  <= plane_r;
    end
  end

  // --------------------------------------------------------------------------
  // Running-maximum store, one entry per window column of the current window
  // row: {max, row, col}.
  // --------------------------------------------------------------------------
  logic [ENTW-1:0] rd_ent, wr_ent, cur_ent, fwd_ent_r;
  logic            fwd_hit_r;

  mpa_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_WIDTH)
  ) u_partial_ram (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_j_r),
    .wdata (wr_ent),
    .re    (in_fire),
    .raddr (colq_r),
    .rdata (rd_ent)
  );

  // A sample of the same window column accepted in the cycle its predecessor
  // wrote back read the old entry; the written entry is forwarded instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (s1_adv) begin
      fwd_hit_r <= s1_we && in_fire && (colq_r == s1_j_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_we) begin
      fwd_ent_r <= wr_ent;
    end
  end

  assign cur_ent = fwd_hit_r ? fwd_ent_r : rd_ent;

  logic signed [SW-1:0] cur_max, new_max;
  logic [CW-1:0]        cur_row, cur_col, new_row, new_col;
  logic                 take;

  // The first sample of a window always starts the running maximum; later
  // ones replace it only when strictly greater, so ties keep the earliest.
  always_comb begin
    cur_max = cur_ent[ENTW-1 -: SW];
    cur_row = cur_ent[2*CW-1 -: CW];
    cur_col = cur_ent[CW-1:0];
    take    = s1_first_r || (s1_sample_r > cur_max);
    new_max = take ? s1_sample_r : cur_max;
    new_row = take ? s1_row_r : cur_row;
    new_col = take ? s1_col_r : cur_col;
    wr_ent  = {new_max, new_row, new_col};
  end

  // --------------------------------------------------------------------------
  // Output register. A result is loaded on the last sample of a window.
  // --------------------------------------------------------------------------
  logic                       out_valid_r;
  logic signed [SW-1:0]       out_max_r;
  logic [mpa_pkg::POS_W-1:0]  out_mrow_r, out_mcol_r, out_orow_r, out_ocol_r, out_plane_r;
  logic                       out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_max_r   <= new_max;
      out_mrow_r  <= mpa_pkg::POS_W'(new_row);
      out_mcol_r  <= mpa_pkg::POS_W'(new_col);
      out_orow_r  <= mpa_pkg::POS_W'(s1_orow_r);
      out_ocol_r  <= mpa_pkg::POS_W'(s1_j_r);
      out_plane_r <= mpa_pkg::POS_W'(s1_plane_r);
      out_done_r  <= s1_pdone_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_max_r;
  assign out_max_row      = out_mrow_r;
  assign out_max_col      = out_mcol_r;
  assign out_out_row      = out_orow_r;
  assign out_out_col      = out_ocol_r;
  assign out_plane_index  = out_plane_r;
  assign out_plane_done   = out_done_r;

endmodule

`default_nettype wire

>>> hw/rtl/mpa_checker.sv
// ----------------------------------------------------------------------------
// mpa_checker
// Port-level checks of the max pooling core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_with_argmax_core_assert.svh"

module mpa_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [mpa_pkg::SAMPLE_W-1:0] out_pooled_value,
  input wire logic        [mpa_pkg::POS_W-1:0]    out_max_row,
  input wire logic        [mpa_pkg::POS_W-1:0]    out_max_col,
  input wire logic                                out_plane_done,
  input wire logic                                psel,
  input wire logic                                penable,
  input wire logic                                pwrite
);

  // A stalled result transaction keeps its value, maximum position and plane-done flag.
  `MPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pooled_value) && $stable(out_max_row) && $stable(out_max_col) && $stable(out_plane_done), "result changed while stalled")

  // A new result follows an accepted sample that passed through the update stage.
  `MPA_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a sample two cycles before")

  // A register write blocks input during the position rebuild.
  `MPA_ASSERT_NEXT(a_cfg_block, psel && penable && pwrite, !in_ready ##1 !in_ready, "input accepted during position rebuild")

endmodule

bind max_pool_with_argmax_core mpa_checker u_mpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pooled_value (out_pooled_value),
  .out_max_row      (out_max_row),
  .out_max_col      (out_max_col),
  .out_plane_done   (out_plane_done),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite)
);

`default_nettype wire
